[hw/rtl/utrs_pkg.sv]
// Shared widths, codes and defaults of the unique topological rank solver.
package utrs_pkg;

  localparam int TEAM_W   = 7;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;

  localparam int MAX_TEAMS_DEFAULT = 64;

  localparam logic [TEAM_W-1:0] TEAM_COUNT_RESET = 7'd1;

  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FLIP  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SOLVE = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_RANK = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_AMB  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_IMP  = 2'd2;

  typedef logic [TEAM_W-1:0] team_t;

endpackage

[hw/rtl/unique_topological_rank_solver.sv]
// Unique topological rank solver: precedence, in-degree and order memories with a sequencer.
//
//   channel   direction  handshake            word
//   input     in         in_valid / in_ready  mode, team_a, team_b
//   result    out        out_valid / out_ready  team, status, last
//   config    in         cfg_we (no wait)     cfg_wdata -> team_count
//
// A load walks every precedence row (not for the first load of a job); a flip reads both teams and,
// if they are related, reverses the edge between them; an ignored word keeps the sequencer idle. A
// solve copies the in-degrees, scans the row of every team placed, decides, then reads and loads each
// result word; each memory has one read port and the scans visit one entry per cycle. Reset is
// synchronous and clears the control registers and the per-row valid bits of the precedence and
// in-degree memories, so no clearing pass is needed. in_ready is high only while the sequencer is
// idle; a result word waits in the output register while out_ready is low, and only the emit and
// failure steps wait on it.
module unique_topological_rank_solver #(
  parameter int MAX_TEAMS = utrs_pkg::MAX_TEAMS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [utrs_pkg::MODE_W-1:0]   mode,
  input  logic [utrs_pkg::TEAM_W-1:0]   team_a,
  input  logic [utrs_pkg::TEAM_W-1:0]   team_b,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [utrs_pkg::TEAM_W-1:0]   team,
  output logic [utrs_pkg::STATUS_W-1:0] status,
  output logic                          last,
  input  logic                          cfg_we,
  input  logic [utrs_pkg::TEAM_W-1:0]   cfg_wdata
);

  localparam int IW = $clog2(MAX_TEAMS);
  localparam int TW = utrs_pkg::TEAM_W;

  typedef logic [IW-1:0]        idx_t;
  typedef logic [TW-1:0]        cnt_t;
  typedef logic [MAX_TEAMS-1:0] row_t;

  localparam row_t ROW_ONE = row_t'(1);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_LOAD    = 4'd1;
  localparam logic [3:0] S_FLIP_RY = 4'd2;
  localparam logic [3:0] S_FLIP_W1 = 4'd3;
  localparam logic [3:0] S_FLIP_W2 = 4'd4;
  localparam logic [3:0] S_COPY    = 4'd5;
  localparam logic [3:0] S_PASS    = 4'd6;
  localparam logic [3:0] S_ROW     = 4'd7;
  localparam logic [3:0] S_SCAN    = 4'd8;
  localparam logic [3:0] S_EMIT_RD = 4'd9;
  localparam logic [3:0] S_EMIT_LD = 4'd10;
  localparam logic [3:0] S_FAIL    = 4'd11;

  // Memories.
  row_t prec_mem [MAX_TEAMS];
  cnt_t deg_mem  [MAX_TEAMS];
  cnt_t wdeg_mem [MAX_TEAMS];
  cnt_t ord_mem  [MAX_TEAMS];

  // Control registers.
  logic [3:0]     state;
  cnt_t           team_count;
  cnt_t           loaded_count;
  cnt_t           ready_team;
  logic [1:0]     ready_count;
  cnt_t           placed_count;
  cnt_t           scan_i;
  cnt_t           emit_i;
  logic           st_v;
  row_t           row_valid;
  row_t           deg_valid;
  row_t           loaded;

  // Payload registers.
  idx_t st_idx;
  idx_t op_x;
  idx_t op_y;
  row_t row_x;
  row_t row_y;
  row_t row_hold;
  cnt_t deg_x;
  cnt_t deg_y;
  logic flip_fwd;
  row_t prec_q;
  logic prec_vq;
  cnt_t deg_q;
  logic deg_vq;
  cnt_t wdeg_q;
  cnt_t ord_q;

  // Combinational signals.
  logic accept;
  cnt_t a_m1;
  cnt_t b_m1;
  cnt_t rt_m1;
  idx_t a_idx;
  idx_t b_idx;
  idx_t rt_idx;
  idx_t scan_idx;
  logic a_ok;
  logic b_ok;
  logic load_go;
  logic job_start;
  logic flip_go;
  logic solve_go;
  logic scan_live;
  logic load_live;
  logic load_issue;
  logic copy_issue;
  logic scan_issue;
  logic pass_place;
  logic emit_issue;
  logic emit_last;
  logic out_free;
  logic out_load;
  logic fwd;
  logic rev;
  row_t prec_row;
  cnt_t deg_val;
  cnt_t cfg_eff;

  logic prec_re;
  idx_t prec_ra;
  logic prec_we;
  idx_t prec_wa;
  row_t prec_wd;
  logic deg_re;
  idx_t deg_ra;
  logic deg_we;
  idx_t deg_wa;
  cnt_t deg_wd;
  logic wdeg_we;
  cnt_t wdeg_wd;
  logic note;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign a_m1      = team_a - cnt_t'(1);
  assign b_m1      = team_b - cnt_t'(1);
  assign rt_m1     = ready_team - cnt_t'(1);
  assign a_idx     = a_m1[IW-1:0];
  assign b_idx     = b_m1[IW-1:0];
  assign rt_idx    = rt_m1[IW-1:0];
  assign scan_idx  = scan_i[IW-1:0];
  assign a_ok      = (team_a != '0) && (team_a <= team_count);
  assign b_ok      = (team_b != '0) && (team_b <= team_count);

  // A team already loaded in this job is ignored; the loaded set is stale between jobs.
  assign load_go   = accept && (mode == utrs_pkg::MODE_LOAD) && a_ok
                     && (loaded_count < team_count)
                     && !((loaded_count != '0) && loaded[a_idx]);
  assign job_start = load_go && (loaded_count == '0);
  assign flip_go   = accept && (mode == utrs_pkg::MODE_FLIP) && a_ok && b_ok
                     && (team_a != team_b);
  assign solve_go  = accept && (mode == utrs_pkg::MODE_SOLVE);

  assign scan_live  = (scan_i < team_count);
  // A load walks every row, since team_count may have shrunk below a loaded team in this job.
  assign load_live  = (scan_i < cnt_t'(MAX_TEAMS));
  assign load_issue = (state == S_LOAD) && load_live && loaded[scan_idx] && (scan_idx != op_x);
  assign copy_issue = (state == S_COPY) && scan_live;
  assign scan_issue = (state == S_SCAN) && scan_live && row_hold[scan_idx];
  assign pass_place = (state == S_PASS) && (ready_count == 2'd1)
                      && (placed_count < team_count);
  assign out_free   = !out_valid || out_ready;
  assign emit_issue = (state == S_EMIT_RD) && out_free;
  assign emit_last  = (emit_i == (team_count - cnt_t'(1)));
  assign out_load   = (state == S_EMIT_LD) || ((state == S_FAIL) && out_free);

  // Rows and in-degrees that were never written since the job start read as zero.
  assign prec_row = prec_vq ? prec_q : '0;
  assign deg_val  = deg_vq ? deg_q : '0;

  assign fwd = row_x[op_y];
  assign rev = prec_row[op_x];

  always_comb begin
    cfg_eff = cfg_wdata;
    if (cfg_wdata == '0) begin
      cfg_eff = cnt_t'(1);
    end else if (cfg_wdata > cnt_t'(MAX_TEAMS)) begin
      cfg_eff = cnt_t'(MAX_TEAMS);
    end
  end

  // Read port selection.
  always_comb begin
    prec_re = 1'b0;
    prec_ra = '0;
    deg_re  = 1'b0;
    deg_ra  = '0;
    priority if (flip_go) begin
      prec_re = 1'b1;
      prec_ra = a_idx;
      deg_re  = 1'b1;
      deg_ra  = a_idx;
    end else if (state == S_FLIP_RY) begin
      prec_re = 1'b1;
      prec_ra = op_y;
      deg_re  = 1'b1;
      deg_ra  = op_y;
    end else if (load_issue) begin
      prec_re = 1'b1;
      prec_ra = scan_idx;
    end else if (copy_issue) begin
      deg_re  = 1'b1;
      deg_ra  = scan_idx;
    end else if (pass_place) begin
      prec_re = 1'b1;
      prec_ra = rt_idx;
    end
  end

  // Write port selection and the working in-degree stage.
  always_comb begin
    prec_we = 1'b0;
    prec_wa = '0;
    prec_wd = '0;
    deg_we  = 1'b0;
    deg_wa  = '0;
    deg_wd  = '0;
    wdeg_we = 1'b0;
    wdeg_wd = '0;
    note    = 1'b0;
    if (load_go) begin
      // A new team has every loaded team ahead of it and nothing behind it yet.
      deg_we = 1'b1;
      deg_wa = a_idx;
      deg_wd = loaded_count;
    end
    if ((state == S_LOAD) && st_v) begin
      prec_we = 1'b1;
      prec_wa = st_idx;
      prec_wd = prec_row | (ROW_ONE << op_x);
    end
    if (state == S_FLIP_W1) begin
      if (fwd) begin
        prec_we = 1'b1;
        prec_wa = op_x;
        prec_wd = row_x & ~(ROW_ONE << op_y);
        deg_we  = 1'b1;
        deg_wa  = op_y;
        deg_wd  = deg_val - cnt_t'(1);
      end else if (rev) begin
        prec_we = 1'b1;
        prec_wa = op_y;
        prec_wd = prec_row & ~(ROW_ONE << op_x);
        deg_we  = 1'b1;
        deg_wa  = op_x;
        deg_wd  = deg_x - cnt_t'(1);
      end
    end
    if (state == S_FLIP_W2) begin
      prec_we = 1'b1;
      deg_we  = 1'b1;
      if (flip_fwd) begin
        prec_wa = op_y;
        prec_wd = row_y | (ROW_ONE << op_x);
        deg_wa  = op_x;
        deg_wd  = deg_x + cnt_t'(1);
      end else begin
        prec_wa = op_x;
        prec_wd = row_x | (ROW_ONE << op_y);
        deg_wa  = op_y;
        deg_wd  = deg_y + cnt_t'(1);
      end
    end
    if ((state == S_COPY) && st_v) begin
      wdeg_we = 1'b1;
      wdeg_wd = deg_val;
      note    = (deg_val == '0);
    end
    if ((state == S_SCAN) && st_v && (wdeg_q != '0)) begin
      wdeg_we = 1'b1;
      wdeg_wd = wdeg_q - cnt_t'(1);
      note    = (wdeg_q == cnt_t'(1));
    end
  end

  // Memories.
  always_ff @(posedge clk) begin
    if (prec_we) begin
      prec_mem[prec_wa] <= prec_wd;
    end
    if (prec_re) begin
      prec_q  <= prec_mem[prec_ra];
      prec_vq <= row_valid[prec_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (deg_we) begin
      deg_mem[deg_wa] <= deg_wd;
    end
    if (deg_re) begin
      deg_q  <= deg_mem[deg_ra];
      deg_vq <= deg_valid[deg_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (wdeg_we) begin
      wdeg_mem[st_idx] <= wdeg_wd;
    end
    if (scan_issue) begin
      wdeg_q <= wdeg_mem[scan_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (pass_place) begin
      ord_mem[placed_count[IW-1:0]] <= ready_team;
    end
    if (emit_issue) begin
      ord_q <= ord_mem[emit_i[IW-1:0]];
    end
  end

  // Valid bits and the loaded set; the first load of a job clears them all at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      deg_valid <= '0;
      loaded    <= '0;
    end else begin
      row_valid <= (job_start ? '0 : row_valid) | (prec_we ? (ROW_ONE << prec_wa) : '0);
      deg_valid <= (job_start ? '0 : deg_valid) | (deg_we ? (ROW_ONE << deg_wa) : '0);
      loaded    <= (job_start ? '0 : loaded) | (load_go ? (ROW_ONE << a_idx) : '0);
    end
  end

  // Sequencer and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      team_count   <= utrs_pkg::TEAM_COUNT_RESET;
      loaded_count <= '0;
      ready_team   <= '0;
      ready_count  <= '0;
      placed_count <= '0;
      scan_i       <= '0;
      emit_i       <= '0;
      st_v         <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        team_count <= cfg_eff;
      end
      st_v      <= load_issue || copy_issue || scan_issue;
      out_valid <= out_load || (out_valid && !out_ready);
      if (note) begin
        if (ready_count == 2'd0) begin
          ready_team <= cnt_t'(st_idx) + cnt_t'(1);
        end
        if (ready_count != 2'd2) begin
          ready_count <= ready_count + 2'd1;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (load_go) begin
            loaded_count <= loaded_count + cnt_t'(1);
            scan_i       <= '0;
            if (loaded_count != '0) begin
              state <= S_LOAD;
            end
          end
          if (flip_go) begin
            state <= S_FLIP_RY;
          end
          if (solve_go) begin
            ready_team   <= '0;
            ready_count  <= '0;
            placed_count <= '0;
            scan_i       <= '0;
            loaded_count <= '0;
            state        <= S_COPY;
          end
        end
        S_LOAD: begin
          if (load_live) begin
            scan_i <= scan_i + cnt_t'(1);
          end else begin
            state <= S_IDLE;
          end
        end
        S_FLIP_RY: state <= S_FLIP_W1;
        S_FLIP_W1: state <= (fwd || rev) ? S_FLIP_W2 : S_IDLE;
        S_FLIP_W2: state <= S_IDLE;
        S_COPY: begin
          if (scan_live) begin
            scan_i <= scan_i + cnt_t'(1);
          end else begin
            state <= S_PASS;
          end
        end
        S_PASS: begin
          if (pass_place) begin
            placed_count <= placed_count + cnt_t'(1);
            ready_count  <= '0;
            state        <= S_ROW;
          end else if (placed_count == team_count) begin
            emit_i <= '0;
            state  <= S_EMIT_RD;
          end else begin
            state <= S_FAIL;
          end
        end
        S_ROW: begin
          scan_i <= '0;
          state  <= S_SCAN;
        end
        S_SCAN: begin
          if (scan_live) begin
            scan_i <= scan_i + cnt_t'(1);
          end else begin
            state <= S_PASS;
          end
        end
        S_EMIT_RD: begin
          if (emit_issue) begin
            state <= S_EMIT_LD;
          end
        end
        S_EMIT_LD: begin
          emit_i <= emit_i + cnt_t'(1);
          state  <= emit_last ? S_IDLE : S_EMIT_RD;
        end
        S_FAIL: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Operands, held rows and the result word.
  always_ff @(posedge clk) begin
    st_idx <= scan_idx;
    if (flip_go || load_go) begin
      op_x <= a_idx;
      op_y <= b_idx;
    end
    if (state == S_FLIP_RY) begin
      row_x <= prec_row;
      deg_x <= deg_val;
    end
    if (state == S_FLIP_W1) begin
      row_y    <= prec_row;
      deg_y    <= deg_val;
      flip_fwd <= fwd;
    end
    if (state == S_ROW) begin
      row_hold <= prec_row;
    end
    if (out_load) begin
      if (state == S_EMIT_LD) begin
        team   <= ord_q;
        status <= utrs_pkg::STATUS_RANK;
        last   <= emit_last;
      end else begin
        team   <= '0;
        status <= (ready_count == 2'd2) ? utrs_pkg::STATUS_AMB : utrs_pkg::STATUS_IMP;
        last   <= 1'b1;
      end
    end
  end

  a_team_count_range: assert property (@(posedge clk) disable iff (rst)
    (team_count != '0) && (team_count <= cnt_t'(MAX_TEAMS)))
    else $error("team_count left its range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || out_ready))
    else $error("result word overwritten before it was taken");

  a_stage_in_scan: assert property (@(posedge clk) disable iff (rst)
    st_v |-> ((state == S_LOAD) || (state == S_COPY) || (state == S_SCAN)))
    else $error("scan stage busy outside a scan");

  a_placed_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_PASS) |-> (placed_count <= team_count))
    else $error("more teams placed than in the job");

  a_fail_word: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != utrs_pkg::STATUS_RANK)) |-> ((team == '0) && last))
    else $error("failure word carries a team or is not last");

endmodule

[sim/tb_unique_topological_rank_solver.sv]
// Self-checking testbench: ranking jobs against a behavioral predictor of the rank solver.
module tb_unique_topological_rank_solver;

  typedef logic [utrs_pkg::MODE_W-1:0] mode_code_t;

  localparam mode_code_t MODE_UNUSED = 2'd3;
  localparam int PHASE_ITEMS   = 34;
  localparam int SETTLE_CYCLES = 200;
  localparam int TEAM_SLOTS    = 64;

  typedef struct packed {
    mode_code_t      mode;
    utrs_pkg::team_t a;
    utrs_pkg::team_t b;
  } rank_cmd_t;

  typedef struct packed {
    utrs_pkg::team_t               team;
    logic [utrs_pkg::STATUS_W-1:0] status;
    logic                          last;
  } rank_word_t;

  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  mode_code_t                    mode      = utrs_pkg::MODE_LOAD;
  utrs_pkg::team_t               team_a    = '0;
  utrs_pkg::team_t               team_b    = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  utrs_pkg::team_t               team;
  logic [utrs_pkg::STATUS_W-1:0] status;
  logic                          last;
  logic                          cfg_we    = 1'b0;
  utrs_pkg::team_t               cfg_wdata = '0;

  rank_cmd_t  cmd_q[$];
  rank_word_t ranking_q[$];

  int unsigned send_idle_pct = 16;
  int unsigned recv_idle_pct = 77;
  int unsigned fail_count        = 0;
  int unsigned words_checked     = 0;
  int unsigned cmds_accepted     = 0;
  int unsigned ranked_solves     = 0;
  int unsigned ambiguous_solves  = 0;
  int unsigned impossible_solves = 0;

  // Predicted state of the solver.
  logic [TEAM_SLOTS-1:0] prec_rows [TEAM_SLOTS] = '{default: '0};
  utrs_pkg::team_t       indeg     [TEAM_SLOTS] = '{default: '0};
  utrs_pkg::team_t       rank_order[TEAM_SLOTS] = '{default: '0};
  int unsigned           loaded_n = 0;
  int unsigned           teams    = 32'(utrs_pkg::TEAM_COUNT_RESET);

  unique_topological_rank_solver i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .team_a    (team_a),
    .team_b    (team_b),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .team      (team),
    .status    (status),
    .last      (last),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    fail_count++;
  endtask

  function automatic bit team_in_range(utrs_pkg::team_t t);
    return t >= 1 && t <= teams;
  endfunction

  function automatic void apply_rank_entry(utrs_pkg::team_t t);
    int unsigned k;
    if (!team_in_range(t) || loaded_n >= teams) return;
    for (k = 0; k < loaded_n; k++)
      if (rank_order[k] == t) return;
    // The first entry of a job starts from an empty graph.
    if (loaded_n == 0) begin
      for (k = 0; k < TEAM_SLOTS; k++) begin
        prec_rows[k] = '0;
        indeg[k]     = '0;
      end
    end
    for (k = 0; k < loaded_n; k++) begin
      prec_rows[rank_order[k] - 1][t - 1] = 1'b1;
      indeg[t - 1]++;
    end
    rank_order[loaded_n] = t;
    loaded_n++;
  endfunction

  function automatic void apply_flip(utrs_pkg::team_t x, utrs_pkg::team_t y);
    int unsigned xi, yi;
    if (!team_in_range(x) || !team_in_range(y) || x == y) return;
    xi = x - 1;
    yi = y - 1;
    if (prec_rows[xi][yi]) begin
      prec_rows[xi][yi] = 1'b0;
      prec_rows[yi][xi] = 1'b1;
      indeg[yi]--;
      indeg[xi]++;
    end else if (prec_rows[yi][xi]) begin
      prec_rows[yi][xi] = 1'b0;
      prec_rows[xi][yi] = 1'b1;
      indeg[xi]--;
      indeg[yi]++;
    end
  endfunction

  // Kahn's sort on a copy of the in-degrees; a second ready team means the order is ambiguous.
  function automatic void solve_ranking();
    utrs_pkg::team_t       deg [TEAM_SLOTS];
    logic [TEAM_SLOTS-1:0] row;
    rank_word_t            words[$];
    int unsigned           n, i, placed, rdy_cnt, rdy_team;
    n        = teams;
    deg      = indeg;
    rdy_cnt  = 0;
    rdy_team = 0;
    placed   = 0;
    for (i = 0; i < n; i++) begin
      if (deg[i] == 0) begin
        if (rdy_cnt == 0) rdy_team = i + 1;
        if (rdy_cnt < 2) rdy_cnt++;
      end
    end
    while (rdy_cnt == 1 && placed < n) begin
      row = prec_rows[rdy_team - 1];
      words.insert(words.size(), rank_word_t'{team: utrs_pkg::team_t'(rdy_team),
                                              status: utrs_pkg::STATUS_RANK,
                                              last: 1'b0});
      placed++;
      rdy_cnt = 0;
      for (i = 0; i < n; i++) begin
        if (row[i] && deg[i] != 0) begin
          deg[i]--;
          if (deg[i] == 0) begin
            if (rdy_cnt == 0) rdy_team = i + 1;
            if (rdy_cnt < 2) rdy_cnt++;
          end
        end
      end
    end
    loaded_n = 0;
    if (placed == n) begin
      words[n - 1].last = 1'b1;
      foreach (words[k]) ranking_q.insert(ranking_q.size(), words[k]);
      ranked_solves++;
    end else begin
      ranking_q.insert(ranking_q.size(),
                       rank_word_t'{team: '0,
                                    status: (rdy_cnt >= 2) ? utrs_pkg::STATUS_AMB
                                                           : utrs_pkg::STATUS_IMP,
                                    last: 1'b1});
      if (rdy_cnt >= 2) ambiguous_solves++;
      else impossible_solves++;
    end
  endfunction

  // Driver: a new word goes out only once the current one is taken.
  always @(posedge clk) begin : driver
    rank_cmd_t c;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        c = cmd_q.pop_front();
        in_valid <= 1'b1;
        mode     <= c.mode;
        team_a   <= c.a;
        team_b   <= c.b;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : monitor
    rank_word_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        cmds_accepted++;
        case (mode)
          utrs_pkg::MODE_LOAD:  apply_rank_entry(team_a);
          utrs_pkg::MODE_FLIP:  apply_flip(team_a, team_b);
          utrs_pkg::MODE_SOLVE: solve_ranking();
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        words_checked++;
        if (ranking_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word team %0d status %0d last %0d",
                                    team, status, last));
        end else begin
          want = ranking_q.pop_front();
          if (team !== want.team)
            report_mismatch($sformatf("team %0d, predicted %0d", team, want.team));
          if (status !== want.status)
            report_mismatch($sformatf("status %0d, predicted %0d", status, want.status));
          if (last !== want.last)
            report_mismatch($sformatf("last %0d, predicted %0d", last, want.last));
        end
      end
    end
  end

  function automatic void push_cmd(mode_code_t m, utrs_pkg::team_t a, utrs_pkg::team_t b);
    cmd_q.insert(cmd_q.size(), rank_cmd_t'{mode: m, a: a, b: b});
  endfunction

  function automatic utrs_pkg::team_t rand_team(int unsigned hi, int unsigned lo);
    return utrs_pkg::team_t'($urandom_range(hi, lo));
  endfunction

  // Mostly teams of the job, with zero and out-of-range values mixed in.
  function automatic utrs_pkg::team_t noise_team(int unsigned n);
    case ($urandom_range(3))
      0:       return rand_team(127, 0);
      default: return rand_team(n + 1, 0);
    endcase
  endfunction

  // A full or sparse ranking, a few flips and a solve; returns the number of useful words.
  function automatic int unsigned queue_ranked_job(int unsigned n);
    utrs_pkg::team_t perm[TEAM_SLOTS];
    utrs_pkg::team_t tmp;
    int unsigned     i, j, count;
    bit              sparse;
    for (i = 0; i < n; i++) perm[i] = utrs_pkg::team_t'(i + 1);
    for (i = n - 1; i > 0; i--) begin
      j       = $urandom_range(i, 0);
      tmp     = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    sparse = ($urandom_range(3) == 0);
    count  = 0;
    for (i = 0; i < n; i++) begin
      if (!sparse || $urandom_range(3) != 0) begin
        push_cmd(utrs_pkg::MODE_LOAD, perm[i], rand_team(127, 0));
        count++;
      end
      if ($urandom_range(9) == 0) begin
        case ($urandom_range(2))
          0:       push_cmd(utrs_pkg::MODE_LOAD, perm[$urandom_range(i, 0)], rand_team(127, 0));
          1:       push_cmd(utrs_pkg::MODE_LOAD, noise_team(n), rand_team(127, 0));
          default: push_cmd(MODE_UNUSED, rand_team(127, 0), rand_team(127, 0));
        endcase
      end
    end
    for (j = $urandom_range(3); j > 0; j--) begin
      // Swapping neighbors keeps the order unique; other pairs tend to close a cycle.
      case ($urandom_range(3))
        0, 1: begin
          if (n >= 2) begin
            i = $urandom_range(n - 2, 0);
            if ($urandom_range(1)) push_cmd(utrs_pkg::MODE_FLIP, perm[i], perm[i + 1]);
            else push_cmd(utrs_pkg::MODE_FLIP, perm[i + 1], perm[i]);
          end else begin
            push_cmd(utrs_pkg::MODE_FLIP, perm[0], perm[0]);
          end
        end
        2:       push_cmd(utrs_pkg::MODE_FLIP, rand_team(n, 1), rand_team(n, 1));
        default: push_cmd(utrs_pkg::MODE_FLIP, noise_team(n), noise_team(n));
      endcase
      count++;
    end
    push_cmd(utrs_pkg::MODE_SOLVE, rand_team(127, 0), rand_team(127, 0));
    return count + 1;
  endfunction

  function automatic int unsigned queue_noise_job(int unsigned n);
    int unsigned k, count;
    count = $urandom_range(10, 3);
    for (k = count; k > 0; k--)
      push_cmd(mode_code_t'($urandom_range(3)), noise_team(n), noise_team(n));
    if ($urandom_range(9) < 7) begin
      push_cmd(utrs_pkg::MODE_SOLVE, rand_team(127, 0), rand_team(127, 0));
      count++;
    end
    return count;
  endfunction

  task automatic set_team_count(input utrs_pkg::team_t v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    teams = (v == 0) ? 1 : (v > TEAM_SLOTS) ? TEAM_SLOTS : v;
  endtask

  // A load can still be walking the matrix after the last result word, so wait past it.
  task automatic drain_and_settle();
    while (cmd_q.size() != 0 || in_valid || ranking_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned     regime, step, n, items;
    utrs_pkg::team_t setting;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    set_team_count(7'd4);
    // Stray loads: team zero, a team far above the count.
    push_cmd(utrs_pkg::MODE_LOAD, 7'd0, 7'd0);
    push_cmd(utrs_pkg::MODE_LOAD, 7'd127, 7'd127);
    // Ranking 2 4 1 3 with a duplicate entry right after the first.
    push_cmd(utrs_pkg::MODE_LOAD, 7'd2, 7'd0);
    push_cmd(utrs_pkg::MODE_LOAD, 7'd2, 7'd0);
    push_cmd(utrs_pkg::MODE_LOAD, 7'd4, 7'd0);
    push_cmd(utrs_pkg::MODE_LOAD, 7'd1, 7'd0);
    push_cmd(utrs_pkg::MODE_LOAD, 7'd3, 7'd0);
    push_cmd(MODE_UNUSED, 7'd127, 7'd127);
    push_cmd(utrs_pkg::MODE_FLIP, 7'd2, 7'd2);
    push_cmd(utrs_pkg::MODE_FLIP, 7'd1, 7'd5);
    push_cmd(utrs_pkg::MODE_FLIP, 7'd2, 7'd4);
    push_cmd(utrs_pkg::MODE_SOLVE, 7'd0, 7'd0);
    // Teams 3 and 4 left out, so they are unrelated and the order is ambiguous.
    push_cmd(utrs_pkg::MODE_LOAD, 7'd1, 7'd0);
    push_cmd(utrs_pkg::MODE_LOAD, 7'd2, 7'd0);
    push_cmd(utrs_pkg::MODE_FLIP, 7'd3, 7'd4);
    push_cmd(utrs_pkg::MODE_SOLVE, 7'd127, 7'd127);
    // Reversing 1 and 3 closes the cycle 1 2 3.
    push_cmd(utrs_pkg::MODE_LOAD, 7'd1, 7'd0);
    push_cmd(utrs_pkg::MODE_LOAD, 7'd2, 7'd0);
    push_cmd(utrs_pkg::MODE_LOAD, 7'd3, 7'd0);
    push_cmd(utrs_pkg::MODE_LOAD, 7'd4, 7'd0);
    push_cmd(utrs_pkg::MODE_FLIP, 7'd1, 7'd3);
    push_cmd(utrs_pkg::MODE_SOLVE, 7'd0, 7'd0);
    push_cmd(utrs_pkg::MODE_LOAD, 7'd3, 7'd0);
    drain_and_settle();
    // One entry already held with a count of one: the next load is one too many.
    set_team_count(7'd1);
    push_cmd(utrs_pkg::MODE_LOAD, 7'd1, 7'd0);
    push_cmd(utrs_pkg::MODE_SOLVE, 7'd0, 7'd0);
    drain_and_settle();

    for (regime = 0; regime < 3; regime++) begin
      case (regime)
        0:       begin send_idle_pct = 16; recv_idle_pct = 77; end
        1:       begin send_idle_pct = 77; recv_idle_pct = 16; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      for (step = 0; step < 4; step++) begin
        if (regime == 0 && step == 0) setting = 7'd64;
        else if (regime == 0 && step == 1) setting = 7'd0;
        else if (regime == 1 && step == 0) setting = 7'd127;
        else if (regime == 2 && step == 0) setting = 7'd1;
        else if (regime == 2 && step == 3) setting = rand_team(40, 11);
        else setting = rand_team(10, 2);
        set_team_count(setting);
        n     = teams;
        items = 0;
        while (items < PHASE_ITEMS) begin
          if ($urandom_range(9) < 8) items += queue_ranked_job(n);
          else items += queue_noise_job(n);
        end
        drain_and_settle();
      end
    end

    $display("Sent %0d command words over three idling patterns and 14 team counts,",
             cmds_accepted);
    $display("checked %0d result words from %0d ranked, %0d ambiguous, %0d impossible solves.",
             words_checked, ranked_solves, ambiguous_solves, impossible_solves);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #200_000_000;
    $display("Timed out with %0d result words outstanding.", ranking_q.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

[files.f]
hw/rtl/utrs_pkg.sv
hw/rtl/unique_topological_rank_solver.sv
sim/tb_unique_topological_rank_solver.sv
